### src/ccs_pkg.sv
`timescale 1ns / 1ps

package ccs_pkg;

    localparam int DATA_W  = 8;
    localparam int KEY_W   = 256;
    localparam int NONCE_W = 96;
    localparam int CTR_W   = 32;
    localparam int POS_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [15:0][31:0] words_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_PART_0      = 3'd0,
        CFG_KEY_PART_1      = 3'd1,
        CFG_KEY_PART_2      = 3'd2,
        CFG_KEY_PART_3      = 3'd3,
        CFG_NONCE_LOW       = 3'd4,
        CFG_NONCE_HIGH      = 3'd5,
        CFG_INITIAL_COUNTER = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              restart;
        logic              new_message;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [CTR_W-1:0] counter;
    } core_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    typedef enum logic {
        BACK_RUN,
        BACK_WAIT
    } back_state_t;

    function automatic words_t init_state(
        input logic [KEY_W-1:0]   key,
        input logic [CTR_W-1:0]   counter,
        input logic [NONCE_W-1:0] nonce
    );
        words_t s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        for (int i = 0; i < 8; i++)
        begin
            s[4+i] = key[32*i +: 32];
        end
        s[12] = counter;
        s[13] = nonce[31:0];
        s[14] = nonce[63:32];
        s[15] = nonce[95:64];
        return s;
    endfunction

endpackage

### src/ccs_front.sv
`timescale 1ns / 1ps

module ccs_front
    import ccs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    output item_t             head,
    output logic              head_valid,
    input  logic              pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              do_pop;
    item_t             in_item;

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    // tuser bit 0 is restart, bit 1 is new message
    always_comb
    begin
        in_item.data        = s_tdata;
        in_item.restart     = s_tuser[0];
        in_item.new_message = s_tuser[1];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/ccs_core.sv
`timescale 1ns / 1ps

module ccs_core
    import ccs_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [KEY_W-1:0]   key,
    input  logic [NONCE_W-1:0] nonce,
    input  core_req_t          req,
    output core_sts_t          sts,
    input  logic [POS_W-1:0]   rd_pos,
    output logic [DATA_W-1:0]  ks_byte
);

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    core_state_t       state_reg, state_next;
    words_t            w_reg, w_next;
    words_t            w_rnd;
    words_t            init_words;
    logic [CTR_W-1:0]  ctr_reg, ctr_next;
    logic [1:0]        step_reg, step_next;
    logic              diag_reg, diag_next;
    logic [DR_W-1:0]   dr_reg, dr_next;
    logic [31:0]       rd_word;

    assign init_words = init_state(key, (state_reg == CORE_IDLE) ? req.counter : ctr_reg, nonce);

    assign rd_word = w_reg[rd_pos[5:2]];
    assign ks_byte = rd_word[8*rd_pos[1:0] +: 8];

    // one quarter-round step on all four columns or diagonals
    always_comb
    begin
        logic [1:0]  lo;
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] p, q, r, s, x, rt;
        w_rnd = w_reg;
        for (int i = 0; i < 4; i++)
        begin
            lo = 2'(i);
            ia = {2'b00, lo};
            ib = {2'b01, lo + {1'b0, diag_reg}};
            ic = {2'b10, lo + {diag_reg, 1'b0}};
            id = {2'b11, lo + {diag_reg, diag_reg}};
            p  = step_reg[0] ? w_reg[ic] : w_reg[ia];
            q  = step_reg[0] ? w_reg[id] : w_reg[ib];
            r  = step_reg[0] ? w_reg[ib] : w_reg[id];
            s  = p + q;
            x  = r ^ s;
            case (step_reg)
                2'd0:    rt = {x[15:0], x[31:16]};
                2'd1:    rt = {x[19:0], x[31:20]};
                2'd2:    rt = {x[23:0], x[31:24]};
                default: rt = {x[24:0], x[31:25]};
            endcase
            if (step_reg[0])
            begin
                w_rnd[ic] = s;
                w_rnd[ib] = rt;
            end
            else
            begin
                w_rnd[ia] = s;
                w_rnd[id] = rt;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        ctr_next   = ctr_reg;
        step_next  = step_reg;
        diag_next  = diag_reg;
        dr_next    = dr_reg;
        sts.busy   = (state_reg != CORE_IDLE);
        sts.done   = 1'b0;
        case (state_reg)
            CORE_IDLE:
            begin
                if (req.start)
                begin
                    w_next     = init_words;
                    ctr_next   = req.counter;
                    step_next  = '0;
                    diag_next  = 1'b0;
                    dr_next    = '0;
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                w_next    = w_rnd;
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    diag_next = !diag_reg;
                    if (diag_reg)
                    begin
                        dr_next = dr_reg + 1'b1;
                        if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1))
                        begin
                            state_next = CORE_FINAL;
                        end
                    end
                end
            end
            CORE_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_next[i] = w_reg[i] + init_words[i];
                end
                sts.done   = 1'b1;
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            step_reg  <= '0;
            diag_reg  <= 1'b0;
            dr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            diag_reg  <= diag_next;
            dr_reg    <= dr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        ctr_reg <= ctr_next;
    end

endmodule

### src/ccs_back.sv
`timescale 1ns / 1ps

module ccs_back
    import ccs_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [KEY_W-1:0]   key,
    input  logic [NONCE_W-1:0] nonce,
    input  logic [CTR_W-1:0]   initial_counter,
    input  item_t              head,
    input  logic               head_valid,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata
);

    back_state_t        state_reg, state_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ready_reg, ready_next;
    logic               fresh_reg, fresh_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_free;
    logic               regen;
    logic [CTR_W-1:0]   ctr_eff;
    logic [DATA_W-1:0]  ks_byte;
    core_req_t          core_req;
    core_sts_t          core_sts;

    ccs_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key),
        .nonce   (nonce),
        .req     (core_req),
        .sts     (core_sts),
        .rd_pos  (pos_reg),
        .ks_byte (ks_byte)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    // a flag on the head word acts once; after its block is made the word just consumes it
    assign regen   = !ready_reg || (!fresh_reg && (head.restart || head.new_message));
    assign ctr_eff = (head.restart && !fresh_reg) ? initial_counter : ctr_reg;

    always_comb
    begin
        state_next       = state_reg;
        ctr_next         = ctr_reg;
        pos_next         = pos_reg;
        ready_next       = ready_reg;
        fresh_next       = fresh_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        pop              = 1'b0;
        core_req.start   = 1'b0;
        core_req.counter = ctr_eff;
        case (state_reg)
            BACK_RUN:
            begin
                if (head_valid && out_free && !core_sts.busy)
                begin
                    if (regen)
                    begin
                        core_req.start = 1'b1;
                        ctr_next       = ctr_eff + 1'b1;
                        ready_next     = 1'b0;
                        state_next     = BACK_WAIT;
                    end
                    else
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = head.data ^ ks_byte;
                        pos_next       = pos_reg + 1'b1;
                        fresh_next     = 1'b0;
                        if (pos_reg == '1)
                        begin
                            ready_next = 1'b0;
                        end
                    end
                end
            end
            BACK_WAIT:
            begin
                if (core_sts.done)
                begin
                    ready_next = 1'b1;
                    fresh_next = 1'b1;
                    pos_next   = '0;
                    state_next = BACK_RUN;
                end
            end
            default:
            begin
                state_next = BACK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_RUN;
            ctr_reg       <= '0;
            pos_reg       <= '0;
            ready_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            pos_reg       <= pos_next;
            ready_reg     <= ready_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### src/chacha20_stream_cipher.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   tdata: data_in; tuser: restart, new_message
// m_*       out        m_tvalid / m_tready   tdata: data_out
// cfg_*     in         cfg_valid / cfg_ready index 0..6, data up to 64 bits
//
// one word per cycle while the current 64-byte keystream block lasts, input waits and the output is not stalled
// a new block is computed in the shared round unit
// (four quarter-round lanes, one add step per cycle) before the waiting word goes out
// reset clears counter, position and block state; keystream words hold no reset value
// the input queue keeps accepting, until it is full, while the output register or the round unit stalls

module chacha20_stream_cipher
    import ccs_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // [7:0] data_in
    input  logic [1:0]            s_tuser,    // [0] restart, [1] new_message
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,    // [7:0] data_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [63:0]       key_part_0_reg;
    logic [63:0]       key_part_1_reg;
    logic [63:0]       key_part_2_reg;
    logic [63:0]       key_part_3_reg;
    logic [63:0]       nonce_low_reg;
    logic [31:0]       nonce_high_reg;
    logic [CTR_W-1:0]  initial_counter_reg;
    logic [KEY_W-1:0]  key;
    logic [NONCE_W-1:0] nonce;
    item_t             head;
    logic              head_valid;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign key   = {key_part_3_reg, key_part_2_reg, key_part_1_reg, key_part_0_reg};
    assign nonce = {nonce_high_reg, nonce_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_part_0_reg      <= '0;
            key_part_1_reg      <= '0;
            key_part_2_reg      <= '0;
            key_part_3_reg      <= '0;
            nonce_low_reg       <= '0;
            nonce_high_reg      <= '0;
            initial_counter_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_PART_0:      key_part_0_reg      <= cfg_data;
                CFG_KEY_PART_1:      key_part_1_reg      <= cfg_data;
                CFG_KEY_PART_2:      key_part_2_reg      <= cfg_data;
                CFG_KEY_PART_3:      key_part_3_reg      <= cfg_data;
                CFG_NONCE_LOW:       nonce_low_reg       <= cfg_data;
                CFG_NONCE_HIGH:      nonce_high_reg      <= cfg_data[31:0];
                CFG_INITIAL_COUNTER: initial_counter_reg <= cfg_data[CTR_W-1:0];
                default:             ;
            endcase
        end
    end

    ccs_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    ccs_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .key             (key),
        .nonce           (nonce),
        .initial_counter (initial_counter_reg),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

### test/chacha20_stream_cipher_tb.sv
`timescale 1ns / 1ps

module chacha20_stream_cipher_tb;
    import ccs_pkg::*;

    localparam int DBL_ROUNDS   = 10;
    localparam int BLOCK_CYCLES = 8 * DBL_ROUNDS + 2;
    localparam int DRAIN_CYCLES = 2 * BLOCK_CYCLES + 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int SEGMENTS     = 5;
    localparam int SEG_ITEMS    = 90;

    // no register lives at this index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              restart;
        logic              new_msg;
        logic              typed;
        logic [DATA_W-1:0] want;
    } step_row_t;

    // all-zero key, nonce and counter: block 0 starts 76 b8 e0 ad
    localparam int DIR_ROWS = 24;
    localparam step_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 8'h76},
        '{8'hFF, 1'b0, 1'b0, 1'b1, 8'h47},
        '{8'h00, 1'b1, 1'b0, 1'b1, 8'h76},
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'hB8},
        '{8'h5A, 1'b1, 1'b1, 1'b1, 8'h2C},
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'hB8},
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'hE0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'hAD},
        '{8'hA5, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b0, 1'b1, 8'h77},
        '{8'h80, 1'b0, 1'b0, 1'b1, 8'h38},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hFE, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h3C, 1'b1, 1'b1, 1'b0, 8'h00},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hAA, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;    // [7:0] data_in
    logic [1:0]            s_tuser;    // [0] restart, [1] new_message
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;    // [7:0] data_out
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register shadows
    logic [63:0] key_q [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
    logic [63:0] nonce_lo_q = '0;
    logic [31:0] nonce_hi_q = '0;
    logic [31:0] ctr_init_q = '0;

    // keystream generator state
    logic [31:0]       blk_ctr  = '0;
    logic [7:0]        ks_bytes [64];
    logic [POS_W-1:0]  ks_pos   = '0;
    logic              ks_valid = 1'b0;

    logic [DATA_W-1:0] pending_cipher [$];

    int idle_mode    = 0;
    int error_count  = 0;
    int bytes_sent   = 0;
    int bytes_seen   = 0;
    int blocks_made  = 0;
    int ctr_wraps    = 0;
    int restarts     = 0;
    int new_msgs     = 0;
    int cfg_writes   = 0;

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS(DBL_ROUNDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter_round(input logic [31:0] a, b, c, d);
        a = a + b; d = rol32(d ^ a, 16);
        c = c + d; b = rol32(b ^ c, 12);
        a = a + b; d = rol32(d ^ a, 8);
        c = c + d; b = rol32(b ^ c, 7);
        return {d, c, b, a};
    endfunction

    function void refill_keystream();
        words_t      init;
        words_t      x;
        logic [31:0] v;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2*i] = key_q[i][31:0];
            init[5 + 2*i] = key_q[i][63:32];
        end
        init[12] = blk_ctr;
        init[13] = nonce_lo_q[31:0];
        init[14] = nonce_lo_q[63:32];
        init[15] = nonce_hi_q;
        x = init;
        for (int r = 0; r < DBL_ROUNDS; r++)
        begin
            // column round then diagonal round
            {x[12], x[8],  x[4], x[0]} = quarter_round(x[0], x[4], x[8],  x[12]);
            {x[13], x[9],  x[5], x[1]} = quarter_round(x[1], x[5], x[9],  x[13]);
            {x[14], x[10], x[6], x[2]} = quarter_round(x[2], x[6], x[10], x[14]);
            {x[15], x[11], x[7], x[3]} = quarter_round(x[3], x[7], x[11], x[15]);
            {x[15], x[10], x[5], x[0]} = quarter_round(x[0], x[5], x[10], x[15]);
            {x[12], x[11], x[6], x[1]} = quarter_round(x[1], x[6], x[11], x[12]);
            {x[13], x[8],  x[7], x[2]} = quarter_round(x[2], x[7], x[8],  x[13]);
            {x[14], x[9],  x[4], x[3]} = quarter_round(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < 16; i++)
        begin
            v = x[i] + init[i];
            for (int j = 0; j < 4; j++)
            begin
                ks_bytes[4*i + j] = v[8*j +: 8];
            end
        end
        if (blk_ctr == 32'hFFFF_FFFF)
        begin
            ctr_wraps++;
        end
        blk_ctr     = blk_ctr + 32'd1;
        ks_pos      = '0;
        ks_valid    = 1'b1;
        blocks_made++;
    endfunction

    function logic [7:0] xor_keystream(input logic [7:0] d, input logic rs, input logic nm);
        logic [7:0] k;
        // restart wins over new message
        if (rs)
        begin
            blk_ctr  = ctr_init_q;
            ks_valid = 1'b0;
            ks_pos   = '0;
        end
        else if (nm)
        begin
            ks_valid = 1'b0;
            ks_pos   = '0;
        end
        if (!ks_valid)
        begin
            refill_keystream();
        end
        k      = ks_bytes[ks_pos];
        ks_pos = ks_pos + 1'b1;
        if (ks_pos == '0)
        begin
            ks_valid = 1'b0;
        end
        return d ^ k;
    endfunction

    function bit sender_idles();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 19;
            1:       return $urandom_range(0, 99) < 67;
            default: return 1'b0;
        endcase
    endfunction

    function bit receiver_idles();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 67;
            1:       return $urandom_range(0, 99) < 19;
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] d, input logic rs, input logic nm,
                             input logic typed, input logic [7:0] typed_want);
        logic [7:0] want;
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= {nm, rs};
        do
            @(posedge clk);
        while (!s_tready);
        want = xor_keystream(d, rs, nm);
        if (typed)
        begin
            want = typed_want;
        end
        pending_cipher.push_back(want);
        bytes_sent++;
        if (rs)
        begin
            restarts++;
        end
        else if (nm)
        begin
            new_msgs++;
        end
    endtask

    // caller lowers cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_KEY_PART_0:      key_q[0]   = val;
            CFG_KEY_PART_1:      key_q[1]   = val;
            CFG_KEY_PART_2:      key_q[2]   = val;
            CFG_KEY_PART_3:      key_q[3]   = val;
            CFG_NONCE_LOW:       nonce_lo_q = val;
            CFG_NONCE_HIGH:      nonce_hi_q = val[31:0];
            CFG_INITIAL_COUNTER: ctr_init_q = val[31:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_cipher.size() != 0)
        begin
            @(posedge clk);
        end
        // a margin of quiet cycles before the registers change
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input int seg);
        logic [63:0] val;
        for (int i = 0; i < 7; i++)
        begin
            case (seg)
                0:       val = '1;
                2:       val = (i < 4) ? 64'd0 : {$urandom, $urandom};
                default: val = {$urandom, $urandom};
            endcase
            // one setting only touches some registers, the rest keep their values
            if (seg != 3 || $urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_IDX_W'(i), val);
            end
        end
        if (seg == 2)
        begin
            write_reg(CFG_INITIAL_COUNTER, {$urandom, 32'hFFFF_FFFE});
        end
        write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                bytes_seen++;
                if (pending_cipher.size() == 0)
                begin
                    report_mismatch("unexpected word, data_out", m_tdata, 8'h00);
                end
                else
                begin
                    logic [7:0] want;
                    want = pending_cipher.pop_front();
                    if (m_tdata !== want)
                    begin
                        report_mismatch("data_out", m_tdata, want);
                    end
                end
            end
            m_tready <= !receiver_idles();
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles, %0d words outstanding",
                 STALL_LIMIT, pending_cipher.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] d;
        logic       rs;
        logic       nm;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].restart,
                      DIRECTED_ROWS[i].new_msg, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_and_settle();
            load_setting(seg);
            idle_mode = (seg < 2) ? 0 : (seg < 4) ? 1 : 2;
            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
                // open with a restart and run past the first block before flags appear, so in the
                // segment that loads a counter near the top a counter wrap is always reached
                rs = (k == 0) || (k >= 65 && $urandom_range(0, 15) == 0);
                nm = (k >= 64) && ($urandom_range(0, 9) == 0);
                send_byte(d, rs, nm, 1'b0, 8'h00);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_cipher.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in, %0d words out, %0d keystream blocks, %0d counter wraps",
                 bytes_sent, bytes_seen, blocks_made, ctr_wraps);
        $display("%0d restarts, %0d new-message marks, %0d register writes, %0d mismatches",
                 restarts, new_msgs, cfg_writes, error_count);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### chacha20_stream_cipher.f
src/ccs_pkg.sv
src/ccs_front.sv
src/ccs_core.sv
src/ccs_back.sv
src/chacha20_stream_cipher.sv
test/chacha20_stream_cipher_tb.sv
